### hdl/nsf_pkg.sv
// near-square factor pair: shared types, control word layout and the microcode rom
// no dependencies; used by nsf_seq, nsf_dp and the top level
`timescale 1ns / 1ps
`default_nettype none

package nsf_pkg;

	// datapath operation selected by the current control word
	typedef enum logic [2:0] {
		OP_LOAD,
		OP_ROOT_INIT,
		OP_ROOT_STEP,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_NEXT_DIV,
		OP_FOUND,
		OP_EMIT
	} op_t;

	// jump condition; the jump is taken when the condition holds, else the step advances
	typedef enum logic [2:0] {
		C_NEVER,
		C_NO_INPUT,
		C_ZERO,
		C_CNT_NZ,
		C_REM_NZ,
		C_OUT_BUSY
	} cond_t;

	typedef logic [2:0] step_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ucw_t;

	// status flags the datapath hands back to the sequencer
	typedef struct packed {
		logic no_input;
		logic zero;
		logic cnt_nz;
		logic rem_nz;
		logic out_busy;
	} status_t;

	localparam step_t ST_WAIT  = 3'd0;
	localparam step_t ST_ZCHK  = 3'd1;
	localparam step_t ST_ROOT  = 3'd2;
	localparam step_t ST_DINIT = 3'd3;
	localparam step_t ST_DIV   = 3'd4;
	localparam step_t ST_TEST  = 3'd5;
	localparam step_t ST_FOUND = 3'd6;
	localparam step_t ST_EMIT  = 3'd7;

	// the program; advancing past the last step wraps back to the wait step
	function automatic ucw_t nsf_ucode(input step_t step);
		ucw_t w;
		unique case (step)
			ST_WAIT:  w = '{op: OP_LOAD,      cond: C_NO_INPUT, target: ST_WAIT};
			ST_ZCHK:  w = '{op: OP_ROOT_INIT, cond: C_ZERO,     target: ST_EMIT};
			ST_ROOT:  w = '{op: OP_ROOT_STEP, cond: C_CNT_NZ,   target: ST_ROOT};
			ST_DINIT: w = '{op: OP_DIV_INIT,  cond: C_NEVER,    target: ST_WAIT};
			ST_DIV:   w = '{op: OP_DIV_STEP,  cond: C_CNT_NZ,   target: ST_DIV};
			ST_TEST:  w = '{op: OP_NEXT_DIV,  cond: C_REM_NZ,   target: ST_DIV};
			ST_FOUND: w = '{op: OP_FOUND,     cond: C_NEVER,    target: ST_WAIT};
			ST_EMIT:  w = '{op: OP_EMIT,      cond: C_OUT_BUSY, target: ST_EMIT};
			default:  w = '{op: OP_LOAD,      cond: C_NEVER,    target: ST_WAIT};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### hdl/nsf_seq.sv
// near-square factor pair: step counter and microcode fetch with conditional jumps
// depends on nsf_pkg for the control word layout and the program rom
`timescale 1ns / 1ps
`default_nettype none

module nsf_seq (
	input  wire              clk,
	input  wire              arst_n,
	input  nsf_pkg::status_t status,
	output nsf_pkg::op_t     op
);

	nsf_pkg::step_t step_q;
	nsf_pkg::ucw_t  ucw;
	logic           take;

	assign ucw = nsf_pkg::nsf_ucode(step_q);
	assign op  = ucw.op;

	always_comb begin
		unique case (ucw.cond)
			nsf_pkg::C_NEVER:    take = 1'b0;
			nsf_pkg::C_NO_INPUT: take = status.no_input;
			nsf_pkg::C_ZERO:     take = status.zero;
			nsf_pkg::C_CNT_NZ:   take = status.cnt_nz;
			nsf_pkg::C_REM_NZ:   take = status.rem_nz;
			nsf_pkg::C_OUT_BUSY: take = status.out_busy;
			default:             take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= nsf_pkg::ST_WAIT;
		end else if (take) begin
			step_q <= ucw.target;
		end else begin
			step_q <= step_q + 3'd1;
		end
	end

endmodule

`default_nettype wire

### hdl/nsf_dp.sv
// near-square factor pair: datapath with bit-serial square root and restoring divider
// sharing one remainder register, plus the request ports and the output register
// depends on nsf_pkg for the operation codes and the status struct
`timescale 1ns / 1ps
`default_nettype none

module nsf_dp #(
	parameter int VALUE_BITS = 31
) (
	input  wire                                        clk,
	input  wire                                        arst_n,
	input  nsf_pkg::op_t                               op,
	output nsf_pkg::status_t                           status,
	input  wire                                        s_tvalid,
	output logic                                       s_tready,
	input  wire  [((VALUE_BITS + 7) / 8) * 8 - 1:0]    s_tdata,
	output logic                                       m_tvalid,
	input  wire                                        m_tready,
	output logic [(((VALUE_BITS + 1) / 2 + VALUE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	output logic                                       m_tuser
);

	localparam int SB    = (VALUE_BITS + 1) / 2;
	localparam int RAD_W = 2 * SB;
	localparam int REM_W = SB + 1;
	localparam int CNT_W = $clog2(VALUE_BITS);
	localparam int OUT_W = ((SB + VALUE_BITS + 7) / 8) * 8;

	logic [VALUE_BITS-1:0] value_q;
	logic [VALUE_BITS-1:0] work_q;
	logic [RAD_W-1:0]      rad_q;
	logic [REM_W-1:0]      rem_q;
	logic [SB-1:0]         d_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  found_q;

	logic                  out_valid_q;
	logic                  out_found_q;
	logic [SB-1:0]         out_small_q;
	logic [VALUE_BITS-1:0] out_large_q;

	logic                  accept;
	logic                  out_busy;
	logic                  emit_fire;

	// square root step: two radicand bits a step
	logic [REM_W+1:0]      rem_sq;
	logic [REM_W+1:0]      trial;
	logic                  sq_ge;

	// divide step: one quotient bit a step
	logic [REM_W-1:0]      rem_dv;
	logic [REM_W-1:0]      d_ext;
	logic                  dv_ge;

	assign s_tready  = (op == nsf_pkg::OP_LOAD);
	assign accept    = s_tready & s_tvalid;
	assign out_busy  = out_valid_q & ~m_tready;
	assign emit_fire = (op == nsf_pkg::OP_EMIT) & ~out_busy;

	assign rem_sq = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = {1'b0, d_q, 2'b01};
	assign sq_ge  = (rem_sq >= trial);

	assign rem_dv = {rem_q[SB-1:0], work_q[VALUE_BITS-1]};
	assign d_ext  = {1'b0, d_q};
	assign dv_ge  = (rem_dv >= d_ext);

	assign status.no_input = ~s_tvalid;
	assign status.zero     = (value_q == '0);
	assign status.cnt_nz   = (cnt_q != '0);
	assign status.rem_nz   = (rem_q != '0);
	assign status.out_busy = out_busy;

	always_ff @(posedge clk) begin
		unique case (op)
			nsf_pkg::OP_LOAD: begin
				if (accept) begin
					value_q <= s_tdata[VALUE_BITS-1:0];
				end
			end
			nsf_pkg::OP_ROOT_INIT: begin
				rad_q   <= RAD_W'(value_q);
				rem_q   <= '0;
				d_q     <= '0;
				cnt_q   <= CNT_W'(SB - 1);
				found_q <= 1'b0;
			end
			nsf_pkg::OP_ROOT_STEP: begin
				rad_q <= rad_q << 2;
				cnt_q <= cnt_q - 1'b1;
				if (sq_ge) begin
					rem_q <= REM_W'(rem_sq - trial);
				end else begin
					rem_q <= REM_W'(rem_sq);
				end
				d_q <= {d_q[SB-2:0], sq_ge};
			end
			nsf_pkg::OP_DIV_INIT: begin
				work_q <= value_q;
				rem_q  <= '0;
				cnt_q  <= CNT_W'(VALUE_BITS - 1);
			end
			nsf_pkg::OP_DIV_STEP: begin
				cnt_q  <= cnt_q - 1'b1;
				work_q <= {work_q[VALUE_BITS-2:0], dv_ge};
				if (dv_ge) begin
					rem_q <= rem_dv - d_ext;
				end else begin
					rem_q <= rem_dv;
				end
			end
			nsf_pkg::OP_NEXT_DIV: begin
				// remainder left over: try the next smaller divisor
				if (rem_q != '0) begin
					d_q    <= d_q - 1'b1;
					work_q <= value_q;
					rem_q  <= '0;
					cnt_q  <= CNT_W'(VALUE_BITS - 1);
				end
			end
			nsf_pkg::OP_FOUND: begin
				found_q <= 1'b1;
			end
			nsf_pkg::OP_EMIT: begin
				if (emit_fire) begin
					out_found_q <= found_q;
					out_small_q <= found_q ? d_q : '0;
					out_large_q <= found_q ? work_q : '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = OUT_W'({out_large_q, out_small_q});

	a_found_nonzero : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (out_small_q != '0) && (out_large_q != '0))
		else $error("factor pair reported with a zero factor");

	a_notfound_zero : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (out_small_q == '0) && (out_large_q == '0))
		else $error("result without a factor pair carries nonzero factors");

	a_div_nonzero : assert property (@(posedge clk) disable iff (!arst_n)
		op == nsf_pkg::OP_DIV_STEP |-> d_q != '0)
		else $error("trial division by zero");

	a_emit_hold : assert property (@(posedge clk) disable iff (!arst_n)
		op == nsf_pkg::OP_EMIT && out_busy |=> m_tvalid && $stable(m_tdata))
		else $error("pending result overwritten while the next one waits");

endmodule

`default_nettype wire

### hdl/near_square_factor_pair_unit.sv
// near-square factor pair: top level joining the microcode sequencer and the datapath
// depends on nsf_pkg, nsf_seq and nsf_dp
`timescale 1ns / 1ps
`default_nettype none

// Splits each request value n into the factor pair closest to square. The unit
// takes the floor square root r of n, two bits of n per step, then tries the
// divisors r, r-1, ... down to the first that divides n, each trial being a
// restoring division in the single shared divider, plus fetch and test steps.
// A 31-bit prime near the top of the range takes about 46341 trials. A new
// request is taken only once the previous result has gone into the output
// register, which holds it until the downstream side takes it. m_tuser is 1
// when a pair was found and 0 for a zero request, whose factors are both
// returned as zero.
module near_square_factor_pair_unit #(
	parameter int VALUE_BITS = 31
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     s_tvalid,
	output logic                                    s_tready,
	// number_in
	input  wire  [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output logic                                    m_tvalid,
	input  wire                                     m_tready,
	// small_factor, large_factor
	output logic [(((VALUE_BITS + 1) / 2 + VALUE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	// found
	output logic                                    m_tuser
);

	nsf_pkg::op_t     op;
	nsf_pkg::status_t status;

	nsf_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.op     (op)
	);

	nsf_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.status   (status),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

### test/factor_pair_checker.sv
// result checker for near_square_factor_pair_unit: watches both streams, predicts each pair
// no dependencies; instantiated by testbench beside the unit
`timescale 1ns / 1ps

module factor_pair_checker #(
	parameter int VALUE_BITS = 31,
	parameter int IN_W       = ((VALUE_BITS + 7) / 8) * 8,
	parameter int OUT_W      = (((VALUE_BITS + 1) / 2 + VALUE_BITS + 7) / 8) * 8
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             s_tvalid,
	input  wire             s_tready,
	input  wire [IN_W-1:0]  s_tdata,
	input  wire             m_tvalid,
	input  wire             m_tready,
	input  wire [OUT_W-1:0] m_tdata,
	input  wire             m_tuser,
	output int              fail_count,
	output int              results_waiting
);

	localparam int ROOT_BITS = (VALUE_BITS + 1) / 2;

	typedef struct packed {
		logic                  found;
		logic [ROOT_BITS-1:0]  small_factor;
		logic [VALUE_BITS-1:0] large_factor;
	} factor_pair_t;

	factor_pair_t pending_pairs[$];
	int           failures = 0;
	int           result_index = 0;

	assign fail_count = failures;

	initial results_waiting = 0;

	// root built one bit at a time from the top, then divisors tried downwards
	function automatic factor_pair_t near_square_split(input logic [VALUE_BITS-1:0] number);
		longint unsigned n;
		longint unsigned root;
		longint unsigned trial;
		longint unsigned divisor;
		factor_pair_t    pair;
		n = number;
		pair = '0;
		root = 0;
		for (int i = ROOT_BITS - 1; i >= 0; i--) begin
			trial = root | (64'd1 << i);
			if (trial * trial <= n)
				root = trial;
		end
		for (divisor = root; divisor != 0 && !pair.found; divisor--) begin
			if (n % divisor == 0) begin
				pair.found = 1'b1;
				pair.small_factor = divisor[ROOT_BITS-1:0];
				pair.large_factor = VALUE_BITS'(n / divisor);
			end
		end
		return pair;
	endfunction

	task automatic note_failure(input string what, input factor_pair_t want,
			input factor_pair_t got);
		if (failures < 10)
			$display("%0t: result %0d %s: expected found=%0d small=%0d large=%0d, got found=%0d small=%0d large=%0d",
				$realtime, result_index, what, want.found, want.small_factor,
				want.large_factor, got.found, got.small_factor, got.large_factor);
		failures++;
	endtask

	always @(posedge clk) begin : watch
		factor_pair_t want;
		factor_pair_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				pending_pairs.push_back(near_square_split(s_tdata[VALUE_BITS-1:0]));
			if (m_tvalid && m_tready) begin
				got.found = m_tuser;
				got.small_factor = m_tdata[ROOT_BITS-1:0];
				got.large_factor = m_tdata[ROOT_BITS +: VALUE_BITS];
				if (pending_pairs.size() == 0) begin
					note_failure("with no request waiting", '0, got);
				end else begin
					want = pending_pairs.pop_front();
					if (got.found !== want.found || got.small_factor !== want.small_factor ||
							got.large_factor !== want.large_factor)
						note_failure("mismatch", want, got);
				end
				result_index++;
			end
			results_waiting <= pending_pairs.size();
		end
	end

endmodule

### test/testbench.sv
// top of the near_square_factor_pair_unit regression: clock, reset, request and result streams
// depends on near_square_factor_pair_unit (and its package) and on factor_pair_checker
`timescale 1ns / 1ps

module testbench;

	localparam int VALUE_BITS   = 31;
	localparam int IN_W         = ((VALUE_BITS + 7) / 8) * 8;
	localparam int OUT_W        = (((VALUE_BITS + 1) / 2 + VALUE_BITS + 7) / 8) * 8;
	localparam int N_DIRECTED   = 20;
	localparam int RANDOM_ITEMS = 80;
	localparam int CALM_ITEMS   = 20;
	localparam int IDLE_LIMIT   = 100000;
	localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 1;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tready;
	wire              s_tready;
	wire              m_tvalid;
	wire  [OUT_W-1:0] m_tdata;
	wire              m_tuser;
	int               fail_count;
	int               results_waiting;
	int               idle_cycles = 0;
	bit               calm = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	near_square_factor_pair_unit #(
		.VALUE_BITS(VALUE_BITS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	factor_pair_checker #(
		.VALUE_BITS(VALUE_BITS)
	) pair_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.fail_count     (fail_count),
		.results_waiting(results_waiting)
	);

	// top bit of each word lies above the value and must be ignored
	function automatic logic [IN_W-1:0] directed_word(input int idx);
		case (idx)
			0:       return 32'h0000_0000;
			1:       return 32'h8000_0000;                  // zero with a stray high bit
			2:       return 32'd1;
			3:       return 32'h8000_0001;
			4:       return 32'd2;
			5:       return 32'd3;
			6:       return 32'd4;
			7:       return 32'd6;
			8:       return 32'd12;
			9:       return 32'd35;
			10:      return 32'd97;                         // prime
			11:      return 32'd143;
			12:      return 32'd999;
			13:      return 32'd30030;
			14:      return 32'd65521;                      // largest 16-bit prime
			15:      return 32'd65535;
			16:      return 32'd65536;
			17:      return 32'h4000_0000;                  // 32768 squared
			18:      return 32'd2147395600;                 // largest square, 46340 squared
			default: return 32'd2147441940 | 32'h8000_0000; // 46340 * 46341, near the top
		endcase
	endfunction

	task automatic send_word(input logic [IN_W-1:0] word);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= $urandom;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
	endtask

	// result side: random stall bursts, always ready in the calm tail
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (calm) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				if ($urandom_range(0, 1) == 0) begin
					m_tready <= 1'b0;
					repeat ($urandom_range(1, 13)) @(posedge clk);
				end
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("near_square_factor_pair_unit regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [IN_W-1:0] word;
		longint unsigned a;
		longint unsigned b;
		longint unsigned value;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_word(directed_word(i));

		// mostly products of two close factors: wide values that finish in a few trials
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
			case ($urandom_range(0, 19)) inside
				[0:11]: begin
					a = $urandom_range(1, 46340);
					b = a + $urandom_range(0, 64);
					if (a * b > VALUE_MAX)
						b = a;
					value = a * b;
				end
				[12:16]: value = $urandom_range(0, 4095);
				default: value = $urandom_range(0, 65535);
			endcase
			word = $urandom;
			word[VALUE_BITS-1:0] = value[VALUE_BITS-1:0];
			send_word(word);
		end
		s_tvalid <= 1'b0;

		do @(posedge clk); while (results_waiting != 0);
		repeat (64) @(posedge clk);
		if (fail_count == 0 && results_waiting == 0)
			$display("near_square_factor_pair_unit regression: pass");
		else
			$display("near_square_factor_pair_unit regression: fail");
		$finish;
	end

endmodule
